// ===== rtl/timed_event_priority_queue_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH

// Checks a property on every rising edge while reset is released.
`define TEPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define TEPQ_ASSERT_NEXT(label, clk, rst_n, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== rtl/tepq_pkg.sv =====
package tepq_pkg;

    localparam int CODE_W   = 5;
    localparam int AGENT_W  = 8;
    localparam int SEC_W    = 32;
    localparam int NS_W     = 30;
    localparam int TIME_W   = SEC_W + NS_W;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0]  key;
        logic [CODE_W-1:0]  code;
        logic [AGENT_W-1:0] agent;
    } t_entry;

    typedef struct packed {
        logic do_insert;
        logic do_pop;
        logic occupied;
        logic at_tail;
    } t_cell_ctl;

endpackage

// ===== rtl/tepq_if.sv =====
interface tepq_in_if;
    import tepq_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [CODE_W-1:0]  event_code;
    logic [AGENT_W-1:0] agent_num;
    logic [SEC_W-1:0]   time_seconds;
    logic [NS_W-1:0]    time_nanoseconds;

    modport source (
        output valid, operation, event_code, agent_num, time_seconds, time_nanoseconds,
        input  ready
    );
    modport sink (
        input  valid, operation, event_code, agent_num, time_seconds, time_nanoseconds,
        output ready
    );
endinterface

interface tepq_out_if;
    import tepq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   out_event_code;
    logic [AGENT_W-1:0]  out_agent_num;
    logic [SEC_W-1:0]    out_seconds;
    logic [NS_W-1:0]     out_nanoseconds;
    logic [OCC_W-1:0]    occupancy;

    modport source (
        output valid, status, out_event_code, out_agent_num, out_seconds,
               out_nanoseconds, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, out_event_code, out_agent_num, out_seconds,
               out_nanoseconds, occupancy,
        output ready
    );
endinterface

// ===== rtl/tepq_cell.sv =====
module tepq_cell (
    input  logic                i_clk,
    input  tepq_pkg::t_cell_ctl i_ctl,
    input  tepq_pkg::t_entry    i_new,
    input  tepq_pkg::t_entry    i_prev,
    input  logic                i_prev_gt,
    input  tepq_pkg::t_entry    i_next,
    output tepq_pkg::t_entry    o_entry,
    output logic                o_gt
);
    import tepq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // A stored event later than the new one moves back to make room.
    assign o_gt    = i_ctl.occupied && (r_entry.key > i_new.key);
    assign o_entry = r_entry;

    always_comb begin
        priority if (i_ctl.do_pop) begin
            n_entry = i_next;
        end else if (i_ctl.do_insert && i_prev_gt) begin
            n_entry = i_prev;
        end else if (i_ctl.do_insert && (o_gt || i_ctl.at_tail)) begin
            n_entry = i_new;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

// ===== rtl/timed_event_priority_queue.sv =====
// Channel   Direction  Handshake      Item
// i_cmd     in         valid/ready    operation, event code, agent, seconds, nanoseconds
// o_rsp     out        valid/ready    status, event code, agent, seconds, nanoseconds, occupancy
//
// An item is first held in the input register, then updates the cell row and loads the
// result once any earlier result is taken. No new item is taken while one is held; a stalled
// result holds the item behind it in the input register, and no further item is taken until that
// result leaves. Every cell compares its event time with the new one in the update cycle.
// Reset clears the fill count and the handshake state; cells hold no reset.
module timed_event_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tepq_in_if.sink    i_cmd,
    tepq_out_if.source o_rsp
);
    import tepq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               r_busy;
    logic               r_op;
    t_entry             r_req;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    t_entry             r_out;
    t_entry             n_out;
    logic [OCC_W-1:0]   r_occ;

    logic               w_accept;
    logic               w_exec;
    logic               w_full;
    logic               w_empty;
    logic               w_insert;
    logic               w_pop;
    t_entry             w_entry [QUEUE_DEPTH];
    logic               w_gt    [QUEUE_DEPTH];

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_busy;
    assign w_exec      = r_busy && (!r_out_valid || o_rsp.ready);
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_insert    = w_exec && (r_op == OP_INSERT) && !w_full;
    assign w_pop       = w_exec && (r_op == OP_POP) && !w_empty;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        t_cell_ctl w_ctl;
        t_entry    w_prev;
        logic      w_prev_gt;
        t_entry    w_next;

        assign w_ctl.do_insert = w_insert;
        assign w_ctl.do_pop    = w_pop;
        assign w_ctl.occupied  = (IDX < r_count);
        assign w_ctl.at_tail   = (IDX == r_count);

        if (i == 0) begin : g_head
            assign w_prev    = r_req;
            assign w_prev_gt = 1'b0;
        end else begin : g_body
            assign w_prev    = w_entry[i-1];
            assign w_prev_gt = w_gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[i];
        end else begin : g_inner
            assign w_next = w_entry[i+1];
        end

        tepq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_new     (r_req),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_entry   (w_entry[i]),
            .o_gt      (w_gt[i])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_out    = '0;
        n_status = ST_INSERTED;
        if (r_op == OP_POP) begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_POPPED;
                n_out    = w_entry[0];
                n_count  = r_count - CNT_W'(1);
            end
        end else begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_cmd.operation;
            r_req.key   <= {i_cmd.time_seconds, i_cmd.time_nanoseconds};
            r_req.code  <= i_cmd.event_code;
            r_req.agent <= i_cmd.agent_num;
        end
        if (w_exec) begin
            r_status <= n_status;
            r_out    <= n_out;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.out_event_code  = r_out.code;
    assign o_rsp.out_agent_num   = r_out.agent;
    assign o_rsp.out_seconds     = r_out.key[TIME_W-1:NS_W];
    assign o_rsp.out_nanoseconds = r_out.key[NS_W-1:0];
    assign o_rsp.occupancy       = r_occ;
endmodule

// ===== rtl/tepq_checker.sv =====
`include "timed_event_priority_queue_assert.svh"

module tepq_checker #(
    parameter int QUEUE_DEPTH = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tepq_pkg::STATUS_W-1:0] i_status,
    input logic [tepq_pkg::CODE_W-1:0]   i_code,
    input logic [tepq_pkg::AGENT_W-1:0]  i_agent,
    input logic [tepq_pkg::SEC_W-1:0]    i_sec,
    input logic [tepq_pkg::NS_W-1:0]     i_ns,
    input logic [tepq_pkg::OCC_W-1:0]    i_occ
);
    import tepq_pkg::*;

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    logic w_data_zero;

    assign w_data_zero = (i_code == '0) && (i_agent == '0) && (i_sec == '0) && (i_ns == '0);

    `TEPQ_ASSERT_NEXT(a_accept_spacing, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready, "Item accepted in two consecutive cycles.")
    `TEPQ_ASSERT(a_empty_result, i_clk, i_rst_n,
        i_out_valid && (i_status == ST_EMPTY) |-> (i_occ == '0) && w_data_zero,
        "Empty pop result carries data or a nonzero occupancy.")
    `TEPQ_ASSERT(a_full_result, i_clk, i_rst_n,
        i_out_valid && (i_status == ST_FULL) |-> (i_occ == FULL_OCC) && w_data_zero,
        "Full insert result carries data or a wrong occupancy.")
    `TEPQ_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_sec) && $stable(i_occ),
        "Stalled result changed.")
endmodule

bind timed_event_priority_queue tepq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tepq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_code      (o_rsp.out_event_code),
    .i_agent     (o_rsp.out_agent_num),
    .i_sec       (o_rsp.out_seconds),
    .i_ns        (o_rsp.out_nanoseconds),
    .i_occ       (o_rsp.occupancy)
);
